@@ rtl/core/hbe_pkg.sv @@
// shared types and constants of the heightmap brush editor
// no dependencies

package hbe_pkg;

  localparam int GRID_W_DEF = 256;
  localparam int GRID_H_DEF = 256;
  localparam int HGT_W      = 16;
  localparam int CRD_W      = 9;
  localparam int CNT_W      = 17;
  localparam int DLT_W      = 15;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_STAMP = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    CFG_SHAPE    = 3'd0,
    CFG_RADIUS   = 3'd1,
    CFG_MODE     = 3'd2,
    CFG_STRENGTH = 3'd3,
    CFG_STEP     = 3'd4,
    CFG_WSEL     = 3'd5,
    CFG_MAXH     = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_NONE    = 2'd0,
    MODE_RAISE   = 2'd1,
    MODE_AVERAGE = 2'd2,
    MODE_BLEND   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    SHAPE_CIRCLE  = 2'd0,
    SHAPE_SQUARE  = 2'd1,
    SHAPE_SQUARE2 = 2'd2,
    SHAPE_NONE    = 2'd3
  } shape_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_BOX,
    ST_WR,
    ST_RD,
    ST_RD_WAIT,
    ST_WALK,
    ST_DRAIN,
    ST_DONE
  } st_e;

endpackage

@@ rtl/core/hbe_ram.sv @@
// generic single write port, single read port ram with registered read
// depends on hbe_pkg for default sizes

module hbe_ram #(
  parameter int WIDTH = hbe_pkg::HGT_W,
  parameter int DEPTH = hbe_pkg::GRID_W_DEF * hbe_pkg::GRID_H_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/heightmap_brush_editor.sv @@
// heightmap brush editor top level: cell height and weight stores, stamp walker
// depends on hbe_pkg and hbe_ram
// sequence from accept to done_o: write PREP, WR, DONE; read PREP, RD, RD_WAIT, DONE
// stamp PREP, BOX, WALK over box, DRAIN, DONE; mode none ends after PREP, no shape after BOX
// busy stays high through the done_o cycle, so a new item is accepted only back in idle
// the receiver cannot stall; reset idles the sequencer and restores configuration defaults

module heightmap_brush_editor #(
  parameter int GRID_W = hbe_pkg::GRID_W_DEF,
  parameter int GRID_H = hbe_pkg::GRID_H_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd_i,
  input  logic [7:0]  cell_x_i,
  input  logic [7:0]  cell_z_i,
  input  logic [11:0] pick_x_i,
  input  logic [11:0] pick_z_i,
  input  logic [15:0] height_in_i,
  input  logic [7:0]  weight0_in_i,
  input  logic [7:0]  weight1_in_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  output logic        done_o,
  output logic [15:0] height_out_o,
  output logic [7:0]  weight0_out_o,
  output logic [7:0]  weight1_out_o,
  output logic [16:0] cells_changed_o,
  output logic        applied_o
);
  import hbe_pkg::*;

  localparam int DEPTH = GRID_W * GRID_H;
  localparam int AW    = $clog2(DEPTH);

  // configuration
  shape_e             shape_q;
  logic [10:0]        radius_q;
  mode_e              mode_q;
  logic signed [13:0] strength_q;
  logic [15:0]        step_q;
  logic               wsel_q;
  logic [15:0]        maxh_q;

  st_e state_q, state_d;

  // latched item
  cmd_e        cmd_q;
  logic [7:0]  cx_q, cz_q;
  logic [11:0] px_q, pz_q;
  logic [15:0] hin_q;
  logic [7:0]  w0_q, w1_q;

  // setup
  logic                    cell_in_q;
  logic [AW-1:0]           base_q;
  logic [CRD_W-1:0]        xmin_q, xmax_q, zmin_q, zmax_q, x_q, z_q;
  logic signed [30:0]      prod_q;
  logic [21:0]             r2_q;
  logic signed [DLT_W-1:0] delta_q;

  // walk pipeline
  logic               v1_q, v2_q, v3_q;
  logic [AW-1:0]      addr1_q, addr2_q, addr3_q;
  logic [25:0]        sqx_q, sqz_q;
  logic signed [34:0] p3_q;
  logic [15:0]        h3_q, w3_q;

  // results
  logic [15:0]      hout_q;
  logic [7:0]       w0out_q, w1out_q;
  logic [CNT_W-1:0] count_q;
  logic             applied_q;

  logic accept;
  assign accept      = start && !busy;
  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  // box bounds
  logic [CRD_W-1:0]       ox, oz, xhi, zhi, xmin_d, zmin_d, xmax_d, zmax_d;
  logic [6:0]             fl;
  logic [11:0]            ce_sum;
  logic [7:0]             ce;
  logic signed [CRD_W:0]  xlo, zlo;
  logic                   cell_in_d, stamp_ok;

  assign ox     = CRD_W'(px_q[11:4]);
  assign oz     = CRD_W'(pz_q[11:4]);
  assign fl     = radius_q[10:4];
  assign ce_sum = 12'(radius_q) + 12'd15;
  assign ce     = ce_sum[11:4];
  assign xlo    = $signed({1'b0, ox}) - $signed((CRD_W + 1)'(fl));
  assign zlo    = $signed({1'b0, oz}) - $signed((CRD_W + 1)'(fl));
  assign xhi    = ox + CRD_W'(ce);
  assign zhi    = oz + CRD_W'(ce);
  assign xmin_d = (xlo < 0) ? '0 : xlo[CRD_W-1:0];
  assign zmin_d = (zlo < 0) ? '0 : zlo[CRD_W-1:0];
  assign xmax_d = (int'(xhi) > GRID_W - 1) ? CRD_W'(GRID_W - 1) : xhi;
  assign zmax_d = (int'(zhi) > GRID_H - 1) ? CRD_W'(GRID_H - 1) : zhi;

  assign cell_in_d = (int'(cx_q) < GRID_W) && (int'(cz_q) < GRID_H);
  assign stamp_ok  = (int'(ox) < GRID_W) && (int'(oz) < GRID_H) && (mode_q != MODE_NONE);

  // row base multiplier, shared by cell access and stamp setup
  logic [CRD_W-1:0] mul_z;
  logic [AW-1:0]    base_d;
  assign mul_z  = (state_q == ST_PREP) ? CRD_W'(cz_q) : zmin_q;
  assign base_d = AW'(int'(mul_z) * GRID_W);

  logic [AW-1:0] cell_addr;
  assign cell_addr = base_q + AW'(cx_q);

  // stamp step rounding
  logic signed [31:0] rndd, rshd;
  assign rndd = $signed({prod_q[30], prod_q}) + 32'sd32768;
  assign rshd = rndd >>> 16;

  // walk stage 0
  logic signed [13:0] dx, dz;
  logic signed [27:0] sqx_full, sqz_full;
  logic               last_col;
  assign dx       = $signed({1'b0, x_q, 4'b0000}) - $signed({2'b00, px_q});
  assign dz       = $signed({1'b0, z_q, 4'b0000}) - $signed({2'b00, pz_q});
  assign sqx_full = 28'(dx) * 28'(dx);
  assign sqz_full = 28'(dz) * 28'(dz);
  assign last_col = (x_q == xmax_q);

  // walk stage 1
  logic [26:0] dist_sq;
  logic        keep1;
  assign dist_sq = {1'b0, sqx_q} + {1'b0, sqz_q};
  assign keep1   = v1_q && ((shape_q != SHAPE_CIRCLE) || (dist_sq < 27'(r2_q)));

  // stores
  logic          h_we, w_we, re;
  logic [AW-1:0] waddr, raddr;
  logic [15:0]   h_wdata, w_wdata, h_rdata, w_rdata;

  // walk stage 2
  logic signed [17:0] diff2;
  logic signed [34:0] prod2;
  assign diff2 = $signed({{4{strength_q[13]}}, strength_q}) - $signed({2'b00, h_rdata});
  assign prod2 = 35'(diff2) * 35'($signed({1'b0, step_q}));

  // walk stage 3
  logic signed [35:0] rnd3, rsh3;
  logic signed [18:0] avg_sum;
  logic signed [17:0] raise_sum;
  logic signed [15:0] wsum;
  logic [7:0]         wb, new_w;
  logic [15:0]        raise_h, avg_h, new_h;
  assign rnd3      = $signed({p3_q[34], p3_q}) + 36'sd32768;
  assign rsh3      = rnd3 >>> 16;
  assign avg_sum   = $signed({3'b000, h3_q}) + $signed(rsh3[18:0]);
  assign raise_sum = $signed({2'b00, h3_q}) + $signed({{3{delta_q[DLT_W-1]}}, delta_q});
  assign wb        = wsel_q ? w3_q[15:8] : w3_q[7:0];
  assign wsum      = $signed({8'h00, wb}) + $signed({delta_q[DLT_W-1], delta_q});
  assign raise_h   = (raise_sum < 18'sd0) ? 16'h0000 :
                     (raise_sum > $signed({2'b00, maxh_q})) ? maxh_q : raise_sum[15:0];
  assign avg_h     = (avg_sum < 19'sd0) ? 16'h0000 :
                     (avg_sum > 19'sd65535) ? 16'hFFFF : avg_sum[15:0];
  assign new_w     = (wsum < 16'sd0) ? 8'h00 : (wsum > 16'sd255) ? 8'hFF : wsum[7:0];
  assign new_h     = (mode_q == MODE_AVERAGE) ? avg_h : raise_h;

  assign h_we    = ((state_q == ST_WR) && cell_in_q) || (v3_q && (mode_q != MODE_BLEND));
  assign w_we    = ((state_q == ST_WR) && cell_in_q) || (v3_q && (mode_q == MODE_BLEND));
  assign waddr   = (state_q == ST_WR) ? cell_addr : addr3_q;
  assign h_wdata = (state_q == ST_WR) ? hin_q : new_h;
  assign w_wdata = (state_q == ST_WR) ? {w1_q, w0_q} :
                   wsel_q ? {new_w, w3_q[7:0]} : {w3_q[15:8], new_w};
  assign re      = ((state_q == ST_RD) && cell_in_q) || keep1;
  assign raddr   = (state_q == ST_RD) ? cell_addr : addr1_q;

  hbe_ram #(.WIDTH(HGT_W), .DEPTH(DEPTH)) u_height_ram (
    .clk_i   (clk_i),
    .we_i    (h_we),
    .waddr_i (waddr),
    .wdata_i (h_wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (h_rdata)
  );

  hbe_ram #(.WIDTH(HGT_W), .DEPTH(DEPTH)) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (waddr),
    .wdata_i (w_wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (w_rdata)
  );

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shape_q    <= SHAPE_CIRCLE;
      radius_q   <= 11'd80;
      mode_q     <= MODE_NONE;
      strength_q <= '0;
      step_q     <= 16'd1092;
      wsel_q     <= 1'b0;
      maxh_q     <= 16'hFFFF;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_SHAPE:    shape_q    <= shape_e'(cfg_data_i[1:0]);
        CFG_RADIUS:   radius_q   <= cfg_data_i[10:0];
        CFG_MODE:     mode_q     <= mode_e'(cfg_data_i[1:0]);
        CFG_STRENGTH: strength_q <= $signed(cfg_data_i[13:0]);
        CFG_STEP:     step_q     <= cfg_data_i;
        CFG_WSEL:     wsel_q     <= cfg_data_i[0];
        CFG_MAXH:     maxh_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        unique case (cmd_q)
          CMD_WRITE: state_d = ST_WR;
          CMD_READ:  state_d = ST_RD;
          CMD_STAMP: state_d = stamp_ok ? ST_BOX : ST_DONE;
          default:   state_d = ST_DONE;
        endcase
      end
      ST_BOX: begin
        state_d = (shape_q == SHAPE_NONE) ? ST_DONE : ST_WALK;
      end
      ST_WR:      state_d = ST_DONE;
      ST_RD:      state_d = ST_RD_WAIT;
      ST_RD_WAIT: state_d = ST_DONE;
      ST_WALK: begin
        if (last_col && (z_q == zmax_q)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!v1_q && !v2_q && !v3_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  assign done_o = (state_q == ST_DONE);

  // item latch and setup
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_e'(cmd_i);
      cx_q  <= cell_x_i;
      cz_q  <= cell_z_i;
      px_q  <= pick_x_i;
      pz_q  <= pick_z_i;
      hin_q <= height_in_i;
      w0_q  <= weight0_in_i;
      w1_q  <= weight1_in_i;
    end
    if (state_q == ST_PREP) begin
      cell_in_q <= cell_in_d;
      base_q    <= base_d;
      xmin_q    <= xmin_d;
      xmax_q    <= xmax_d;
      zmin_q    <= zmin_d;
      zmax_q    <= zmax_d;
      prod_q    <= 31'(strength_q) * 31'($signed({1'b0, step_q}));
      r2_q      <= 22'(radius_q) * 22'(radius_q);
    end
    if (state_q == ST_BOX) begin
      base_q  <= base_d;
      delta_q <= rshd[DLT_W-1:0];
      x_q     <= xmin_q;
      z_q     <= zmin_q;
    end
    if (state_q == ST_WALK) begin
      if (last_col) begin
        x_q    <= xmin_q;
        z_q    <= z_q + CRD_W'(1);
        base_q <= base_q + AW'(GRID_W);
      end else begin
        x_q <= x_q + CRD_W'(1);
      end
    end
  end

  // walk pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= (state_q == ST_WALK);
      v2_q <= keep1;
      v3_q <= v2_q;
    end
  end

  // walk pipeline payload
  always_ff @(posedge clk_i) begin
    addr1_q <= base_q + AW'(x_q);
    sqx_q   <= sqx_full[25:0];
    sqz_q   <= sqz_full[25:0];
    addr2_q <= addr1_q;
    addr3_q <= addr2_q;
    p3_q    <= prod2;
    h3_q    <= h_rdata;
    w3_q    <= w_rdata;
  end

  // results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hout_q    <= '0;
      w0out_q   <= '0;
      w1out_q   <= '0;
      count_q   <= '0;
      applied_q <= 1'b0;
    end else begin
      if (accept) begin
        hout_q    <= '0;
        w0out_q   <= '0;
        w1out_q   <= '0;
        count_q   <= '0;
        applied_q <= 1'b0;
      end else begin
        if ((state_q == ST_PREP) && (cmd_q == CMD_STAMP)) begin
          applied_q <= stamp_ok;
        end
        if ((state_q == ST_RD_WAIT) && cell_in_q) begin
          hout_q  <= h_rdata;
          w0out_q <= w_rdata[7:0];
          w1out_q <= w_rdata[15:8];
        end
        if (v3_q) begin
          count_q <= count_q + CNT_W'(1);
        end
      end
    end
  end

  assign height_out_o    = hout_q;
  assign weight0_out_o   = w0out_q;
  assign weight1_out_o   = w1out_q;
  assign cells_changed_o = count_q;
  assign applied_o       = applied_q;

endmodule
